FILE: src/bae_pkg.sv
// ----------------------------------------------------------------------------
// Bus enumerator package
// Types, constants and phase codes shared by the enumerator modules.
// ----------------------------------------------------------------------------
package bae_pkg;

  localparam int MaxNestDepth = 8;
  localparam int SlotsPerBus  = 32;
  localparam int DepthW       = $clog2(MaxNestDepth + 1);
  localparam int StackIdxW    = (MaxNestDepth > 1) ? $clog2(MaxNestDepth) : 1;

  localparam logic [7:0] OffVendor = 8'h00;
  localparam logic [7:0] OffClass  = 8'h08;
  localparam logic [7:0] OffHeader = 8'h0C;
  localparam logic [7:0] OffBus    = 8'h18;

  typedef enum logic [1:0] {
    KIND_REQ    = 2'd0,
    KIND_REPORT = 2'd1,
    KIND_DONE   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CFG_MODE     = 2'd0,
    CFG_CLASS    = 2'd1,
    CFG_SUBCLASS = 2'd2,
    CFG_PROG_IF  = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE, PH_SLOT_VEN, PH_SLOT_HDR, PH_DEV_VEN, PH_DEV_ID,
    PH_PROGIF, PH_SUBCL, PH_CLASS, PH_HDR, PH_SEC
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_WAIT, ST_DECIDE, ST_ADVANCE, ST_POP, ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    ACT_NONE, ACT_START, ACT_CAPTURE, ACT_NEXT_FUNC, ACT_NEXT_SLOT,
    ACT_POP_REQ, ACT_POP_LOAD, ACT_PUSH
  } act_t;

  typedef struct packed {
    act_t       act;
    logic       load_resp;
  } dp_cmd_t;

  typedef struct packed {
    logic       vendor_absent;
    logic       func_more;
    logic       slot_more;
    logic       depth_zero;
    logic       can_descend;
    logic       is_bridge;
    logic       multi_bit;
    logic       match;
  } dp_stat_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  bus;
    logic [4:0]  slot;
    logic [2:0]  func;
    logic [7:0]  offset;
    logic [15:0] vendor;
    logic [15:0] device;
    logic [7:0]  base_class;
    logic [7:0]  subclass;
    logic [7:0]  prog_if;
    logic        last;
  } result_t;

endpackage

FILE: src/bae_if.sv
// ----------------------------------------------------------------------------
// Enumerator channel interfaces
// Valid/ready channels for input words, result words and register writes.
// ----------------------------------------------------------------------------
interface bae_in_if;
  import bae_pkg::*;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] read_data;
  modport source(output valid, req_type, read_data, input ready);
  modport sink(input valid, req_type, read_data, output ready);
endinterface

interface bae_out_if;
  import bae_pkg::*;
  logic        valid;
  logic        ready;
  result_t     data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

interface bae_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: src/bridge_aware_bus_enumerator_core.sv
// ----------------------------------------------------------------------------
// Bridge-aware bus enumerator
// Steps: a start word goes straight to the emit state for its first request;
// a response passes the decide state first, and the advance state as well when
// the scan moves to another function or slot; each stack pop at the end of a
// subtree adds the pop and advance states. One word is in work at a time;
// an enumerate-mode report adds an emit step, and a stalled result waits.
// Synchronous reset returns the block to idle with default registers.
// ----------------------------------------------------------------------------
module bridge_aware_bus_enumerator_core
  import bae_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  bae_in_if.sink     in_ch,
  bae_out_if.source  out_ch,
  bae_cfg_if.sink    cfg
);

  logic       scan_mode;
  logic [7:0] match_class;
  logic [7:0] match_subclass;
  logic [7:0] match_prog_if;
  dp_cmd_t    cmd;
  dp_stat_t   stat;
  result_t    pos;
  phase_t     phase;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode      <= 1'b0;
      match_class    <= '0;
      match_subclass <= '0;
      match_prog_if  <= 8'hFF;
    end else if (cfg.valid) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_MODE:     scan_mode      <= cfg.data[0];
        CFG_CLASS:    match_class    <= cfg.data;
        CFG_SUBCLASS: match_subclass <= cfg.data;
        CFG_PROG_IF:  match_prog_if  <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  bae_datapath u_dp (
    .clk, .rst, .cmd, .phase, .resp(in_ch.read_data),
    .scan_mode, .match_class, .match_subclass, .match_prog_if,
    .stat, .pos
  );

  bae_control u_ctl (
    .clk, .rst, .in_ch, .out_ch, .scan_mode, .stat, .pos, .cmd, .phase
  );

endmodule

FILE: src/bae_datapath.sv
// ----------------------------------------------------------------------------
// Enumerator datapath
// Scan position, device fields, parent stack and the result builder.
// ----------------------------------------------------------------------------
module bae_datapath
  import bae_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  input  phase_t      phase,
  input  logic [31:0] resp,
  input  logic        scan_mode,
  input  logic [7:0]  match_class,
  input  logic [7:0]  match_subclass,
  input  logic [7:0]  match_prog_if,
  output dp_stat_t    stat,
  output result_t     pos
);

  logic [7:0]        bus;
  logic [4:0]        slot;
  logic [2:0]        func;
  logic              multi;
  logic [DepthW-1:0] depth;
  logic [31:0]       data;
  logic [15:0]       vendor;
  logic [15:0]       device;
  logic [7:0]        prog_if;
  logic [7:0]        subclass;
  logic [7:0]        base_class;
  logic [16:0]       stack [MaxNestDepth];
  logic [16:0]       top;
  logic [StackIdxW-1:0] pop_idx;

  assign pop_idx = StackIdxW'(depth - DepthW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else begin
      unique case (cmd.act)
        ACT_START:    depth <= '0;
        ACT_POP_REQ:  depth <= depth - DepthW'(1);
        ACT_PUSH:     depth <= depth + DepthW'(1);
        default:      depth <= depth;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    top <= stack[pop_idx];
    if (cmd.act == ACT_PUSH) begin
      stack[StackIdxW'(depth)] <= {bus, slot, func, multi};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_resp) begin
      data <= resp;
    end
    unique case (cmd.act)
      ACT_START: begin
        bus <= '0; slot <= '0; func <= '0; multi <= 1'b0;
        vendor <= '0; device <= '0; prog_if <= '0; subclass <= '0; base_class <= '0;
      end
      ACT_CAPTURE: begin
        case (phase)
          PH_SLOT_HDR: begin
            multi <= data[23];
            func  <= '0;
          end
          PH_DEV_VEN: vendor <= data[15:0];
          PH_DEV_ID:  device <= data[31:16];
          PH_PROGIF:  prog_if <= data[15:8];
          PH_SUBCL:   subclass <= data[23:16];
          PH_CLASS:   base_class <= data[31:24];
          default: begin
          end
        endcase
      end
      ACT_NEXT_FUNC: func <= func + 3'd1;
      ACT_NEXT_SLOT: begin
        slot  <= slot + 5'd1;
        func  <= '0;
        multi <= 1'b0;
      end
      ACT_POP_LOAD: begin
        bus   <= top[16:9];
        slot  <= top[8:4];
        func  <= top[3:1];
        multi <= top[0];
      end
      ACT_PUSH: begin
        bus   <= data[15:8];
        slot  <= '0;
        func  <= '0;
        multi <= 1'b0;
      end
      default: begin
      end
    endcase
    if (cmd.act == ACT_CAPTURE && phase == PH_SLOT_VEN && data[15:0] == 16'hFFFF) begin
      multi <= 1'b0;
      func  <= '0;
    end
  end

  always_comb begin
    stat.vendor_absent = (data[15:0] == 16'hFFFF);
    stat.func_more     = multi && (func != 3'd7);
    stat.slot_more     = ({1'b0, slot} + 6'd1) < 6'(SlotsPerBus);
    stat.depth_zero    = (depth == '0);
    stat.can_descend   = (data[15:8] != 8'h00) && (data[15:8] != bus)
                         && (depth < DepthW'(MaxNestDepth));
    stat.is_bridge     = (data[22:16] == 7'h01);
    stat.multi_bit     = data[23];
    stat.match         = !scan_mode && (data[31:24] == match_class)
                         && (subclass == match_subclass)
                         && (match_prog_if == 8'hFF || prog_if == match_prog_if);
  end

  always_comb begin
    pos            = '0;
    pos.bus        = bus;
    pos.slot       = slot;
    pos.func       = func;
    pos.vendor     = vendor;
    pos.device     = device;
    pos.base_class = base_class;
    pos.subclass   = subclass;
    pos.prog_if    = prog_if;
  end

endmodule

FILE: src/bae_control.sv
// ----------------------------------------------------------------------------
// Enumerator controller
// Walks the scan phases, sequences stack pops and drives the result register.
// ----------------------------------------------------------------------------
module bae_control
  import bae_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  bae_in_if.sink        in_ch,
  bae_out_if.source     out_ch,
  input  logic          scan_mode,
  input  dp_stat_t      stat,
  input  result_t       pos,
  output dp_cmd_t       cmd,
  output phase_t        phase
);

  state_t  state, state_next;
  phase_t  phase_next;
  logic    busy, busy_next;
  logic    report_pend, report_pend_next;
  logic    take;
  logic    out_free;
  logic    emit_done;
  logic    class_match_q;
  logic    final_report;
  logic [7:0] req_off;
  kind_t   emit_kind;
  result_t emit_word;

  assign out_free     = !out_ch.valid || out_ch.ready;
  assign in_ch.ready  = (state == ST_IDLE || state == ST_WAIT);
  assign take         = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      phase       <= PH_IDLE;
      busy        <= 1'b0;
      report_pend <= 1'b0;
    end else begin
      state       <= state_next;
      phase       <= phase_next;
      busy        <= busy_next;
      report_pend <= report_pend_next;
    end
  end

  always_comb begin
    state_next       = state;
    phase_next       = phase;
    busy_next        = busy;
    report_pend_next = report_pend;
    unique case (state)
      ST_IDLE, ST_WAIT: begin
        if (take) begin
          if (!in_ch.req_type) begin
            state_next = ST_EMIT;
            phase_next = PH_SLOT_VEN;
            busy_next  = 1'b1;
          end else if (busy) begin
            state_next = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        state_next = ST_EMIT;
        unique case (phase)
          PH_SLOT_VEN: if (stat.vendor_absent) begin
            state_next = ST_ADVANCE;
          end else begin
            phase_next = PH_SLOT_HDR;
          end
          PH_SLOT_HDR: phase_next = PH_DEV_VEN;
          PH_DEV_VEN:  if (stat.vendor_absent) begin
            state_next = ST_ADVANCE;
          end else begin
            phase_next = PH_DEV_ID;
          end
          PH_DEV_ID:   phase_next = PH_PROGIF;
          PH_PROGIF:   phase_next = PH_SUBCL;
          PH_SUBCL:    phase_next = PH_CLASS;
          PH_CLASS: begin
            if (stat.match) begin
              phase_next = PH_IDLE;
            end else begin
              // A report in enumerate mode precedes the header request of the same function.
              phase_next       = PH_HDR;
              report_pend_next = scan_mode;
            end
          end
          PH_HDR: if (stat.is_bridge) begin
            phase_next = PH_SEC;
          end else begin
            state_next = ST_ADVANCE;
          end
          PH_SEC: if (stat.can_descend) begin
            phase_next = PH_SLOT_VEN;
          end else begin
            state_next = ST_ADVANCE;
          end
          default: begin
            state_next = ST_IDLE;
            phase_next = PH_IDLE;
            busy_next  = 1'b0;
          end
        endcase
      end
      ST_ADVANCE: begin
        if (stat.func_more) begin
          state_next = ST_EMIT;
          phase_next = PH_DEV_VEN;
        end else if (stat.slot_more) begin
          state_next = ST_EMIT;
          phase_next = PH_SLOT_VEN;
        end else if (stat.depth_zero) begin
          state_next = ST_EMIT;
          phase_next = PH_IDLE;
        end else begin
          state_next = ST_POP;
        end
      end
      ST_POP:  state_next = ST_ADVANCE;
      ST_EMIT: begin
        if (out_free) begin
          if (report_pend) begin
            report_pend_next = 1'b0;
          end else if (phase == PH_IDLE) begin
            state_next = ST_IDLE;
            busy_next  = 1'b0;
          end else begin
            state_next = ST_WAIT;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      class_match_q <= 1'b0;
    end else if (take && !in_ch.req_type) begin
      class_match_q <= 1'b0;
    end else if (state == ST_DECIDE && phase == PH_CLASS) begin
      class_match_q <= stat.match;
    end
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE, ST_WAIT: begin
        if (take && !in_ch.req_type) begin
          cmd.act = ACT_START;
        end
        cmd.load_resp = take && in_ch.req_type;
      end
      ST_DECIDE: begin
        if (phase == PH_SEC && stat.can_descend) begin
          cmd.act = ACT_PUSH;
        end else begin
          cmd.act = ACT_CAPTURE;
        end
      end
      ST_ADVANCE: begin
        if (stat.func_more) begin
          cmd.act = ACT_NEXT_FUNC;
        end else if (stat.slot_more) begin
          cmd.act = ACT_NEXT_SLOT;
        end else if (!stat.depth_zero) begin
          cmd.act = ACT_POP_REQ;
        end
      end
      ST_POP:  cmd.act = ACT_POP_LOAD;
      default: cmd.act = ACT_NONE;
    endcase
  end

  always_comb begin
    final_report = (phase == PH_IDLE) && class_match_q;
    emit_done    = (phase == PH_IDLE) && !class_match_q;
    emit_kind    = report_pend || final_report ? KIND_REPORT
                 : (emit_done ? KIND_DONE : KIND_REQ);
    unique case (phase)
      PH_SLOT_HDR, PH_HDR:           req_off = OffHeader;
      PH_PROGIF, PH_SUBCL, PH_CLASS: req_off = OffClass;
      PH_SEC:                        req_off = OffBus;
      default:                       req_off = OffVendor;
    endcase
  end

  always_comb begin
    emit_word      = '0;
    emit_word.kind = emit_kind;
    if (emit_kind == KIND_REQ) begin
      emit_word.bus    = pos.bus;
      emit_word.slot   = pos.slot;
      emit_word.func   = pos.func;
      emit_word.offset = req_off;
    end else if (emit_kind == KIND_REPORT) begin
      emit_word.bus        = pos.bus;
      emit_word.slot       = pos.slot;
      emit_word.func       = pos.func;
      emit_word.vendor     = pos.vendor;
      emit_word.device     = pos.device;
      emit_word.base_class = pos.base_class;
      emit_word.subclass   = pos.subclass;
      emit_word.prog_if    = pos.prog_if;
      emit_word.last       = final_report;
    end else begin
      emit_word.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      out_ch.data <= emit_word;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP) |=> (state == ST_ADVANCE))
    else $error("pop not followed by advance");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE) |-> busy)
    else $error("decision while idle");
  assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
    else $error("result dropped");

endmodule

FILE: verif/bridge_aware_bus_enumerator_core_test.sv
// ----------------------------------------------------------------------------
// Bus enumerator core test
// Plays the part of the configuration space: each input word is chosen from
// the scan position that the test predicts, so that whole scans, bridges and
// the nesting limit are reached. Every result word is checked, field by
// field, against the predicted stream under several idling patterns.
// ----------------------------------------------------------------------------
module bridge_aware_bus_enumerator_core_test;
  import bae_pkg::*;

  localparam int CycleLimit = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bae_in_if  in_ch ();
  bae_out_if out_ch ();
  bae_cfg_if cfg ();

  bridge_aware_bus_enumerator_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register copies and scan state of the predictor.
  logic        mode_enum;
  logic [7:0]  want_class;
  logic [7:0]  want_subclass;
  logic [7:0]  want_prog_if;
  logic        scan_busy;
  logic [7:0]  cur_bus;
  logic [4:0]  cur_slot;
  logic [2:0]  cur_func;
  logic        cur_multi;
  phase_t      cur_phase;
  int          nest;
  logic [16:0] parent_pos [MaxNestDepth];
  logic [55:0] dev_info;

  result_t expected_results [$];
  int      errors = 0;
  int      cycles = 0;
  int      gap_pct = 0;
  int      stall_pct = 0;
  int      density = 30;
  bit      chain = 1'b0;

  task automatic report(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic result_t pos_result(kind_t k, logic [7:0] off, logic [55:0] dv, bit l);
    result_t r;
    r.kind       = k;
    r.bus        = cur_bus;
    r.slot       = cur_slot;
    r.func       = cur_func;
    r.offset     = off;
    r.vendor     = dv[15:0];
    r.device     = dv[31:16];
    r.prog_if    = dv[39:32];
    r.subclass   = dv[47:40];
    r.base_class = dv[55:48];
    r.last       = l;
    return r;
  endfunction

  task automatic issue_read(input logic [7:0] off, input phase_t ph);
    cur_phase = ph;
    expected_results.push_back(pos_result(KIND_REQ, off, '0, 1'b0));
  endtask

  task automatic end_scan();
    result_t r;
    scan_busy = 1'b0;
    cur_phase = PH_IDLE;
    r = pos_result(KIND_DONE, 8'h00, '0, 1'b1);
    r.bus  = '0;
    r.slot = '0;
    r.func = '0;
    expected_results.push_back(r);
  endtask

  task automatic step_past_function();
    logic [16:0] e;
    while (1) begin
      if (32'(cur_func) + 1 < (cur_multi ? 8 : 1)) begin
        cur_func++;
        issue_read(OffVendor, PH_DEV_VEN);
        return;
      end
      if (32'(cur_slot) + 1 < SlotsPerBus) begin
        cur_slot++;
        cur_func  = '0;
        cur_multi = 1'b0;
        issue_read(OffVendor, PH_SLOT_VEN);
        return;
      end
      if (nest == 0) begin
        end_scan();
        return;
      end
      nest--;
      e = parent_pos[nest];
      cur_bus   = e[16:9];
      cur_slot  = e[8:4];
      cur_func  = e[3:1];
      cur_multi = e[0];
    end
  endtask

  task automatic predict_word(input bit typ, input logic [31:0] d);
    logic [7:0] b;
    if (!typ) begin
      scan_busy = 1'b1;
      nest      = 0;
      cur_bus   = '0;
      cur_slot  = '0;
      cur_func  = '0;
      cur_multi = 1'b0;
      dev_info  = '0;
      issue_read(OffVendor, PH_SLOT_VEN);
      return;
    end
    if (!scan_busy) return;
    case (cur_phase)
      PH_SLOT_VEN: begin
        if (d[15:0] == 16'hFFFF) begin
          cur_multi = 1'b0;
          cur_func  = '0;
          step_past_function();
        end else begin
          issue_read(OffHeader, PH_SLOT_HDR);
        end
      end
      PH_SLOT_HDR: begin
        cur_multi = d[23];
        cur_func  = '0;
        issue_read(OffVendor, PH_DEV_VEN);
      end
      PH_DEV_VEN: begin
        if (d[15:0] == 16'hFFFF) begin
          step_past_function();
        end else begin
          dev_info = {40'h0, d[15:0]};
          issue_read(OffVendor, PH_DEV_ID);
        end
      end
      PH_DEV_ID: begin
        dev_info[31:16] = d[31:16];
        issue_read(OffClass, PH_PROGIF);
      end
      PH_PROGIF: begin
        dev_info[39:32] = d[15:8];
        issue_read(OffClass, PH_SUBCL);
      end
      PH_SUBCL: begin
        dev_info[47:40] = d[23:16];
        issue_read(OffClass, PH_CLASS);
      end
      PH_CLASS: begin
        dev_info[55:48] = d[31:24];
        if (!mode_enum) begin
          if (dev_info[55:48] == want_class && dev_info[47:40] == want_subclass &&
              (want_prog_if == 8'hFF || dev_info[39:32] == want_prog_if)) begin
            expected_results.push_back(pos_result(KIND_REPORT, 8'h00, dev_info, 1'b1));
            scan_busy = 1'b0;
            cur_phase = PH_IDLE;
          end else begin
            issue_read(OffHeader, PH_HDR);
          end
        end else begin
          expected_results.push_back(pos_result(KIND_REPORT, 8'h00, dev_info, 1'b0));
          issue_read(OffHeader, PH_HDR);
        end
      end
      PH_HDR: begin
        if (d[22:16] == 7'h01) issue_read(OffBus, PH_SEC);
        else step_past_function();
      end
      PH_SEC: begin
        b = d[15:8];
        if (b != 8'h00 && b != cur_bus && nest < MaxNestDepth) begin
          parent_pos[nest] = {cur_bus, cur_slot, cur_func, cur_multi};
          nest++;
          cur_bus   = b;
          cur_slot  = '0;
          cur_func  = '0;
          cur_multi = 1'b0;
          issue_read(OffVendor, PH_SLOT_VEN);
        end else begin
          step_past_function();
        end
      end
      default: begin
        scan_busy = 1'b0;
        cur_phase = PH_IDLE;
      end
    endcase
  endtask

  // Chooses a plausible response dword for the request now outstanding.
  function automatic logic [31:0] config_dword();
    logic [31:0] r;
    int k;
    r = $urandom;
    case (cur_phase)
      PH_SLOT_VEN: begin
        if (chain ? (cur_slot != 0) : ($urandom_range(99) >= density)) r[15:0] = 16'hFFFF;
        else if (r[15:0] == 16'hFFFF) r[0] = 1'b0;
      end
      PH_SLOT_HDR: r[23] = chain ? 1'b0 : ($urandom_range(99) < 30);
      PH_DEV_VEN: begin
        if (!chain && $urandom_range(99) < (cur_func == 0 ? 5 : 40)) r[15:0] = 16'hFFFF;
        else if (r[15:0] == 16'hFFFF) r[1] = 1'b0;
      end
      PH_PROGIF: if ($urandom_range(99) < 50) r[15:8] = want_prog_if;
      PH_SUBCL: if ($urandom_range(99) < 50) r[23:16] = want_subclass;
      PH_CLASS: if ($urandom_range(99) < 50) r[31:24] = want_class;
      PH_HDR: if (chain || $urandom_range(99) < 25) r[22:16] = 7'h01;
      PH_SEC: begin
        k = $urandom_range(9);
        if (chain) r[15:8] = cur_bus + 8'd1;
        else if (k == 0) r[15:8] = 8'h00;
        else if (k == 1) r[15:8] = cur_bus;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_word(input bit typ, input logic [31:0] d);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.req_type  = typ;
    in_ch.read_data = d;
    do @(posedge clk); while (!in_ch.ready);
    predict_word(typ, d);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] v);
    @(negedge clk);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = v;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      CFG_MODE:     mode_enum     = v[0];
      CFG_CLASS:    want_class    = v;
      CFG_SUBCLASS: want_subclass = v;
      CFG_PROG_IF:  want_prog_if  = v;
      default: ;
    endcase
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic run_out_scan();
    density = 0;
    chain   = 1'b0;
    while (scan_busy) send_word(1'b1, config_dword());
  endtask

  task automatic test_directed();
    send_word(1'b1, $urandom);
    send_word(1'b0, 32'h0000_0000);
    send_word(1'b0, 32'hFFFF_FFFF);
    send_word(1'b1, 32'h1234_8086);
    send_word(1'b1, 32'h0080_0000);
    send_word(1'b1, 32'hABCD_8086);
    send_word(1'b1, 32'h1234_ABCD);
    send_word(1'b1, 32'h0000_0100);
    send_word(1'b1, 32'h0000_0000);
    send_word(1'b1, 32'h0000_0000);
    wait_drained();
    write_reg(CFG_MODE, 8'h01);
    write_reg(CFG_CLASS, 8'hFF);
    write_reg(CFG_SUBCLASS, 8'hFF);
    write_reg(CFG_PROG_IF, 8'h00);
    send_word(1'b0, 32'h0000_0000);
    send_word(1'b1, 32'hFFFE_0000);
    send_word(1'b1, 32'h007F_0000);
    send_word(1'b1, 32'h0000_FFFE);
    send_word(1'b1, 32'hFFFF_0000);
    send_word(1'b1, 32'hFFFF_FFFF);
    send_word(1'b1, 32'hFFFF_FFFF);
    send_word(1'b1, 32'hFFFF_FFFF);
    send_word(1'b1, 32'h0001_0000);
    send_word(1'b1, 32'h0000_0000);
    run_out_scan();
  endtask

  task automatic test_nesting_limit();
    wait_drained();
    write_reg(CFG_MODE, 8'h01);
    chain = 1'b1;
    send_word(1'b0, $urandom);
    while (!(nest == MaxNestDepth && cur_phase == PH_SEC)) send_word(1'b1, config_dword());
    send_word(1'b1, config_dword());
    run_out_scan();
  endtask

  task automatic test_random(input int gap, input int stall, input int n_items);
    int sent;
    bit typ;
    logic [31:0] d;
    wait_drained();
    gap_pct   = gap;
    stall_pct = stall;
    write_reg(CFG_MODE, 8'($urandom_range(1)));
    write_reg(CFG_CLASS, ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom_range(255)));
    write_reg(CFG_SUBCLASS, ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255)));
    write_reg(CFG_PROG_IF, ($urandom_range(2) == 0) ? 8'hFF : 8'($urandom_range(255)));
    sent = 0;
    while (sent < n_items) begin
      if (!scan_busy) typ = ($urandom_range(9) == 0);
      else typ = ($urandom_range(99) >= 2);
      d = ($urandom_range(99) < 3) ? $urandom : config_dword();
      if (!typ) density = $urandom_range(5, 40);
      if (scan_busy || !typ) sent++;
      send_word(typ, d);
    end
    run_out_scan();
  endtask

  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    result_t exp_r;
    result_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (expected_results.size() == 0) begin
        report("result word with no expectation waiting");
      end else begin
        exp_r = expected_results.pop_front();
        if (got.kind !== exp_r.kind)
          report($sformatf("kind %0d, expected %0d", got.kind, exp_r.kind));
        if (got.bus !== exp_r.bus)
          report($sformatf("bus %0h, expected %0h", got.bus, exp_r.bus));
        if (got.slot !== exp_r.slot)
          report($sformatf("slot %0h, expected %0h", got.slot, exp_r.slot));
        if (got.func !== exp_r.func)
          report($sformatf("func %0h, expected %0h", got.func, exp_r.func));
        if (got.offset !== exp_r.offset)
          report($sformatf("offset %0h, expected %0h", got.offset, exp_r.offset));
        if (got.vendor !== exp_r.vendor)
          report($sformatf("vendor %0h, expected %0h", got.vendor, exp_r.vendor));
        if (got.device !== exp_r.device)
          report($sformatf("device %0h, expected %0h", got.device, exp_r.device));
        if (got.base_class !== exp_r.base_class)
          report($sformatf("class %0h, expected %0h",
                           got.base_class, exp_r.base_class));
        if (got.subclass !== exp_r.subclass)
          report($sformatf("subclass %0h, expected %0h", got.subclass, exp_r.subclass));
        if (got.prog_if !== exp_r.prog_if)
          report($sformatf("prog_if %0h, expected %0h", got.prog_if, exp_r.prog_if));
        if (got.last !== exp_r.last)
          report($sformatf("last %0b, expected %0b", got.last, exp_r.last));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.req_type  = 1'b0;
    in_ch.read_data = '0;
    out_ch.ready    = 1'b1;
    cfg.valid       = 1'b0;
    cfg.index       = CFG_MODE;
    cfg.data        = '0;
    mode_enum       = 1'b0;
    want_class      = 8'h00;
    want_subclass   = 8'h00;
    want_prog_if    = 8'hFF;
    scan_busy       = 1'b0;
    cur_bus         = '0;
    cur_slot        = '0;
    cur_func        = '0;
    cur_multi       = 1'b0;
    cur_phase       = PH_IDLE;
    nest            = 0;
    dev_info        = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_nesting_limit();
    test_random(0, 0, 250);
    test_random(64, 0, 250);
    test_random(0, 64, 250);
    test_random(16, 16, 250);
    wait_drained();
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
